### rtl/core/bmh64_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmh64_pkg
// Shared constants, operation codes and types of the streaming block hash.
// ----------------------------------------------------------------------------
package bmh64_pkg;

	localparam logic [63:0] HASH_START = 64'h637f6e65916dff18;
	localparam logic [63:0] MIX_A      = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_B      = 64'h94d049bb133111eb;
	localparam logic [63:0] MIX_T      = 64'hd6e8feb86659fd93;

	localparam int QDEPTH_DEFAULT = 2;

	// operation of one queued beat
	typedef logic [1:0] op_t;
	localparam op_t OP_FULL  = 2'd0;
	localparam op_t OP_TAIL  = 2'd1;
	localparam op_t OP_FLUSH = 2'd2;

	typedef struct packed {
		op_t         op;
		logic        last;
		logic [63:0] word;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	typedef struct packed {
		logic idle;
	} bstat_t;

endpackage
`default_nettype wire

### rtl/core/bmh64_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmh64_in_if
// Message word channel: one little-endian word, its byte count, last flag.
// ----------------------------------------------------------------------------
interface bmh64_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] data_word;
	logic [3:0]  byte_count;
	logic        last;

	modport source (output valid, output data_word, output byte_count, output last,
		input ready);
	modport sink (input valid, input data_word, input byte_count, input last,
		output ready);
endinterface
`default_nettype wire

### rtl/core/bmh64_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmh64_out_if
// Hash result channel: one 64-bit hash per completed message.
// ----------------------------------------------------------------------------
interface bmh64_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] hash_value;

	modport source (output valid, output hash_value, input ready);
	modport sink (input valid, input hash_value, output ready);
endinterface
`default_nettype wire

### rtl/core/bmh64_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmh64_front
// Accepts message beats, classifies them and masks tail bytes for the queue.
// ----------------------------------------------------------------------------
module bmh64_front
	import bmh64_pkg::*;
(
	bmh64_in_if.sink msg,
	input  qstat_t   qstat,
	output logic     push,
	output entry_t   entry
);

	logic [63:0] keep;
	logic        needed;

	// byte lane kept when its index is below the count
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			keep[8*i +: 8] = (4'(i) < msg.byte_count) ? 8'hff : 8'h00;
		end
	end

	always_comb begin
		entry.last = msg.last;
		entry.word = msg.data_word & keep;
		if (msg.byte_count >= 4'd8) begin
			entry.op = OP_FULL;
		end else if (msg.byte_count != 4'd0) begin
			entry.op = OP_TAIL;
		end else begin
			entry.op = OP_FLUSH;
		end
	end

	// empty beat without last changes nothing and is dropped here
	assign needed    = (msg.byte_count != 4'd0) || msg.last;
	assign msg.ready = !qstat.full;
	assign push      = msg.valid && !qstat.full && needed;

endmodule
`default_nettype wire

### rtl/core/bmh64_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmh64_queue
// Short first-in first-out queue between the front and the mixing back end.
// ----------------------------------------------------------------------------
module bmh64_queue
	import bmh64_pkg::*;
#(
	parameter int DEPTH = QDEPTH_DEFAULT
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t wr_entry,
	input  logic   pop,
	output entry_t head,
	output qstat_t qstat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t          mem_q [DEPTH];
	logic [PW-1:0]   wptr_q;
	logic [PW-1:0]   rptr_q;
	logic [CW-1:0]   count_q;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= next_ptr(wptr_q);
			end
			if (pop) begin
				rptr_q <= next_ptr(rptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	assign head        = mem_q[rptr_q];
	assign qstat.full  = (count_q == CW'(DEPTH));
	assign qstat.empty = (count_q == '0);

endmodule
`default_nettype wire

### rtl/core/bmh64_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmh64_back
// Mixing sequencer: adds a queued word to the running hash, runs the
// xor-shift / multiply rounds on a shared split multiplier, emits hashes.
// ----------------------------------------------------------------------------
module bmh64_back
	import bmh64_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  entry_t     head,
	input  qstat_t     qstat,
	output logic       pop,
	output bstat_t     bstat,
	bmh64_out_if.source digest
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_M1L  = 3'd1;
	localparam logic [2:0] ST_M1H  = 3'd2;
	localparam logic [2:0] ST_M2L  = 3'd3;
	localparam logic [2:0] ST_M2H  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	logic [2:0]  state_q;
	logic [63:0] h_q;
	logic        full_q;
	logic        emit_q;
	logic [63:0] acc_q;
	logic [63:0] a_q;
	logic [63:0] lo_q;
	logic        out_valid_q;
	logic [63:0] out_hash_q;

	logic        out_free;
	logic [63:0] xs_in;
	logic [63:0] mul_b;
	logic [31:0] cross_sum;
	logic [63:0] prod;
	logic [63:0] fin_mix;
	logic        do_emit;

	assign out_free = !out_valid_q || digest.ready;

	// operand of the current round, xor-shift folded in front of the multiplier
	always_comb begin
		if (state_q == ST_M1L) begin
			xs_in = full_q ? (acc_q ^ (acc_q >> 30)) : (acc_q ^ (acc_q >> 32));
		end else begin
			xs_in = full_q ? (acc_q ^ (acc_q >> 27)) : (acc_q ^ (acc_q >> 32));
		end
		if (state_q == ST_M1L || state_q == ST_M1H) begin
			mul_b = full_q ? MIX_A : MIX_T;
		end else begin
			mul_b = full_q ? MIX_B : MIX_T;
		end
	end

	// low 64 bits of the product: low partial product, then the cross terms
	assign cross_sum = 32'(a_q[63:32] * mul_b[31:0]) + 32'(a_q[31:0] * mul_b[63:32]);
	assign prod      = lo_q + {cross_sum, 32'd0};
	assign fin_mix   = full_q ? (acc_q ^ (acc_q >> 31)) : (acc_q ^ (acc_q >> 32));

	always_comb begin
		pop     = 1'b0;
		do_emit = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (!qstat.empty) begin
					if (head.op == OP_FLUSH) begin
						pop     = out_free;
						do_emit = out_free;
					end else begin
						pop = 1'b1;
					end
				end
			end
			ST_FIN: begin
				do_emit = emit_q && out_free;
			end
			ST_M1L, ST_M1H, ST_M2L, ST_M2H: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			h_q         <= HASH_START;
			full_q      <= 1'b0;
			emit_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (digest.ready) begin
				out_valid_q <= 1'b0;
			end
			if (do_emit) begin
				out_valid_q <= 1'b1;
				h_q         <= HASH_START;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop && head.op != OP_FLUSH) begin
						full_q  <= (head.op == OP_FULL);
						emit_q  <= (head.op == OP_TAIL) || head.last;
						state_q <= ST_M1L;
					end
				end
				ST_M1L: state_q <= ST_M1H;
				ST_M1H: state_q <= ST_M2L;
				ST_M2L: state_q <= ST_M2H;
				ST_M2H: state_q <= ST_FIN;
				ST_FIN: begin
					if (!emit_q) begin
						h_q     <= fin_mix;
						state_q <= ST_IDLE;
					end else if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && pop) begin
			acc_q <= h_q + head.word;
		end
		if (state_q == ST_M1L || state_q == ST_M2L) begin
			a_q  <= xs_in;
			lo_q <= 64'(xs_in[31:0]) * 64'(mul_b[31:0]);
		end
		if (state_q == ST_M1H || state_q == ST_M2H) begin
			acc_q <= prod;
		end
		if (do_emit) begin
			out_hash_q <= (state_q == ST_FIN) ? fin_mix : h_q;
		end
	end

	assign digest.valid      = out_valid_q;
	assign digest.hash_value = out_hash_q;
	assign bstat.idle        = (state_q == ST_IDLE);

endmodule
`default_nettype wire

### rtl/core/block_mix_hash64.sv
`default_nettype none
// ----------------------------------------------------------------------------
// block_mix_hash64
// Streaming 64-bit hash over a byte message, one little-endian word a beat.
// ----------------------------------------------------------------------------
// A word of 8 valid bytes (counts above 8 act as 8) is added to the running
// hash and mixed with two multiply rounds; a word of 1 to 7 bytes is the tail,
// gets its unused bytes zeroed, is mixed with the tail rounds and always ends
// the message. A beat with count 0 and last set emits the current hash; one
// with count 0 and last clear is accepted and dropped. After each emitted hash
// the running hash restarts. A data word passes the mixing sequencer in order:
// the add, each 64-bit multiply as a low and a high step on the shared split
// multiplier, then the closing xor-shift; an emit-only beat needs no mixing.
// The front accepts up to QDEPTH beats ahead of the sequencer, and the result
// register lets the next message proceed while a hash waits to be taken.
// ----------------------------------------------------------------------------
module block_mix_hash64
	import bmh64_pkg::*;
#(
	parameter int QDEPTH = QDEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	bmh64_in_if.sink    msg,
	bmh64_out_if.source digest
);

	qstat_t qstat;
	bstat_t bstat;
	entry_t wr_entry;
	entry_t head;
	logic   push;
	logic   pop;

	bmh64_front u_front (
		.msg   (msg),
		.qstat (qstat),
		.push  (push),
		.entry (wr_entry)
	);

	bmh64_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	bmh64_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.bstat  (bstat),
		.digest (digest)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("push into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("pop from empty queue");

	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> bstat.idle)
		else $error("pop while sequencer busy");

	a_word_starts_mix: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.op != OP_FLUSH) |=> !bstat.idle)
		else $error("data word popped without starting the mix");

endmodule
`default_nettype wire

### tb/bmh64_digest_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bmh64_digest_checker
// Watches both channels of the block hash, keeps its own running hash and
// compares every digest beat with the oldest hash still owed.
// ----------------------------------------------------------------------------
module bmh64_digest_checker
	import bmh64_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	bmh64_in_if  msg,
	bmh64_out_if digest,
	output int   mismatch_count,
	output int   hashes_matched,
	output int   hashes_owed
);

	logic [63:0] run_hash;
	logic [63:0] pending_hashes[$];

	function automatic logic [63:0] word_round(input logic [63:0] h);
		h ^= h >> 30;
		h = h * MIX_A;
		h ^= h >> 27;
		h = h * MIX_B;
		h ^= h >> 31;
		return h;
	endfunction

	function automatic logic [63:0] tail_round(input logic [63:0] h);
		h ^= h >> 32;
		h = h * MIX_T;
		h ^= h >> 32;
		h = h * MIX_T;
		h ^= h >> 32;
		return h;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_hash       <= HASH_START;
			mismatch_count <= 0;
			hashes_matched <= 0;
			hashes_owed    <= 0;
			pending_hashes.delete();
		end else begin : track
			logic [63:0] h;
			logic [63:0] want;
			logic        emit;

			// digest side first so a beat never matches a hash owed this same edge
			if (digest.valid && digest.ready) begin
				if (pending_hashes.size() == 0) begin
					if (mismatch_count < 10)
						$display("%0t: digest beat %h with no hash owed", $time,
							digest.hash_value);
					mismatch_count <= mismatch_count + 1;
				end else begin
					want = pending_hashes.pop_front();
					if (digest.hash_value !== want) begin
						if (mismatch_count < 10)
							$display("%0t: hash_value expected %h, got %h", $time, want,
								digest.hash_value);
						mismatch_count <= mismatch_count + 1;
					end else begin
						hashes_matched <= hashes_matched + 1;
					end
				end
			end

			if (msg.valid && msg.ready) begin
				h    = run_hash;
				emit = msg.last;
				if (msg.byte_count >= 4'd8) begin
					h = word_round(h + msg.data_word);
				end else if (msg.byte_count != 4'd0) begin
					// tail: bytes past the count are dropped, and it always ends the message
					h    = tail_round(h + (msg.data_word &
						((64'd1 << (8 * msg.byte_count)) - 64'd1)));
					emit = 1'b1;
				end
				if (emit) begin
					pending_hashes.push_back(h);
					run_hash <= HASH_START;
				end else begin
					run_hash <= h;
				end
			end

			hashes_owed <= pending_hashes.size();
		end
	end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Block hash test: directed messages over the count and last corners, then
// random messages with bursty gaps on the word side and stalls on the digest
// side; a checker beside the block predicts and compares every hash.
// ----------------------------------------------------------------------------
module tb;
	import bmh64_pkg::*;

	localparam int ITEM_TARGET = 800;
	localparam int QUIET_FROM  = 680;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	bmh64_in_if  msg();
	bmh64_out_if digest();

	int mismatches;
	int matched;
	int owed;
	int beats_sent;
	int beats_dropped;
	int src_gap_pct;
	int sink_stall_pct;
	bit quiet;

	block_mix_hash64 dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg),
		.digest (digest)
	);

	bmh64_digest_checker chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.msg            (msg),
		.digest         (digest),
		.mismatch_count (mismatches),
		.hashes_matched (matched),
		.hashes_owed    (owed)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int pick_pressure();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 5;
			2: return 25;
			default: return 60;
		endcase
	endfunction

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [3:0] body_count();
		if ($urandom_range(0, 9) == 0)
			return 4'($urandom_range(9, 15));
		return 4'd8;
	endfunction

	task automatic push_beat(input logic [63:0] w, input logic [3:0] n, input logic l);
		if (!quiet && $urandom_range(0, 99) < src_gap_pct) begin
			msg.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		msg.valid      <= 1'b1;
		msg.data_word  <= w;
		msg.byte_count <= n;
		msg.last       <= l;
		@(posedge clk);
		while (!msg.ready) @(posedge clk);
		if (n == 4'd0 && !l)
			beats_dropped++;
		else
			beats_sent++;
	endtask

	task automatic push_message();
		int n_full;
		int pick;

		pick = $urandom_range(0, 9);
		if (pick < 6)
			n_full = $urandom_range(0, 3);
		else if (pick < 9)
			n_full = $urandom_range(4, 8);
		else
			n_full = $urandom_range(9, 16);
		src_gap_pct = pick_pressure();

		for (int i = 0; i < n_full; i++) begin
			// stray empty beat, should leave the hash alone
			if ($urandom_range(0, 19) == 0)
				push_beat(rand_word(), 4'd0, 1'b0);
			push_beat(rand_word(), body_count(), 1'b0);
		end

		case ($urandom_range(0, 3))
			0, 1: push_beat(rand_word(), 4'($urandom_range(1, 7)), 1'($urandom_range(0, 1)));
			2: push_beat(rand_word(), 4'd0, 1'b1);
			default: push_beat(rand_word(), body_count(), 1'b1);
		endcase
	endtask

	initial begin
		digest.ready <= 1'b0;
		sink_stall_pct = 20;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 99) < sink_stall_pct) begin
				digest.ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
			digest.ready <= 1'b1;
			if ($urandom_range(0, 39) == 0)
				sink_stall_pct = pick_pressure();
		end
	end

	initial begin
		msg.valid      <= 1'b0;
		msg.data_word  <= 64'd0;
		msg.byte_count <= 4'd0;
		msg.last       <= 1'b0;
		quiet       = 1'b0;
		src_gap_pct = 20;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty message, then a dropped beat ahead of one
		push_beat(64'd0, 4'd0, 1'b1);
		push_beat(rand_word(), 4'd0, 1'b0);
		push_beat(64'd0, 4'd0, 1'b1);
		push_beat({64{1'b1}}, 4'd8, 1'b1);
		// message ending on a word boundary
		push_beat(64'd0, 4'd8, 1'b0);
		push_beat({64{1'b1}}, 4'd8, 1'b0);
		push_beat(64'd0, 4'd0, 1'b1);
		// every tail size, all ones so the masking shows, last both ways
		for (int n = 1; n <= 7; n++)
			push_beat({64{1'b1}}, 4'(n), 1'(n));
		push_beat(64'haaaa_aaaa_aaaa_aaaa, 4'd8, 1'b0);
		push_beat(64'h5555_5555_5555_5555, 4'd7, 1'b0);
		// oversized counts act as full words
		for (int n = 9; n <= 15; n++)
			push_beat(rand_word(), 4'(n), n == 15);

		while (beats_sent < ITEM_TARGET) begin
			quiet = beats_sent >= QUIET_FROM;
			push_message();
		end

		msg.valid <= 1'b0;
		@(posedge clk);
		while (owed != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("covered %0d beats plus %0d dropped empty beats, %0d hashes compared",
			beats_sent, beats_dropped, matched);
		$display("counts 0 to 15, tails with last high and low, gaps and stalls on both sides");
		if (mismatches == 0 && owed == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#2000000;
		$display("timeout with %0d hashes still owed", owed);
		$display("Mismatches found");
		$finish;
	end

endmodule

### sim.f
rtl/core/bmh64_pkg.sv
rtl/core/bmh64_in_if.sv
rtl/core/bmh64_out_if.sv
rtl/core/bmh64_front.sv
rtl/core/bmh64_queue.sv
rtl/core/bmh64_back.sv
rtl/core/block_mix_hash64.sv
tb/bmh64_digest_checker.sv
tb/tb.sv
